/* rtl/terp_pkg.sv */
// Package: shared types and constants for the trace event ring.
package terp_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int POOL_BYTES_DEF = 65536;
  localparam int MAX_BATCH_DEF  = 64;

  // Slot word: seq, line, depth, thread, time, kind, three refs.
  localparam int SLOT_W = 64 + 31 + 16 + 64 + 64 + 4 + 17 + 17 + 17;

  localparam int IN_DATA_W  = 304;
  localparam int OUT_DATA_W = 328;

  // Action codes
  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_SWAP  = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_FILL  = 3'd4;
  localparam logic [2:0] ACT_DROPS = 3'd5;
  localparam logic [2:0] ACT_OVFL  = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_POOL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CAP  = 1'b0;
  localparam logic CFG_POOL = 1'b1;

  localparam logic [16:0] REF_ABSENT = 17'h1FFFF;
  localparam logic [16:0] REF_OVFL   = 17'h1FFFE;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_OUT,
    ST_RESP
  } ctl_state_t;

endpackage

/* rtl/terp_ram.sv */
// Generic single-port-write, registered-read RAM.
module terp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/terp_alloc.sv */
// Combinational string allocation from the active pool for one push.
module terp_alloc (
  input  logic [16:0] fill,
  input  logic [16:0] limit,
  input  logic [16:0] file_len,
  input  logic [16:0] func_len,
  input  logic [16:0] locals_len,
  output logic [16:0] file_ref,
  output logic [16:0] func_ref,
  output logic [16:0] locals_ref,
  output logic [16:0] fill_next,
  output logic        name_bad,
  output logic        locals_bad
);
  import terp_pkg::*;

  logic [17:0] f_sum, n_sum, l_sum;
  logic [16:0] f_fill, n_fill;
  logic        f_ok, n_ok, l_ok;

  always_comb begin
    f_sum  = {1'b0, fill} + {1'b0, file_len};
    f_ok   = (f_sum <= {1'b0, limit});
    f_fill = (file_len != '0 && f_ok) ? f_sum[16:0] : fill;
    n_sum  = {1'b0, f_fill} + {1'b0, func_len};
    n_ok   = (n_sum <= {1'b0, limit});
    n_fill = (func_len != '0 && n_ok) ? n_sum[16:0] : f_fill;
    l_sum  = {1'b0, n_fill} + {1'b0, locals_len};
    l_ok   = (l_sum <= {1'b0, limit});
    name_bad = (file_len != '0 && !f_ok) || (func_len != '0 && !n_ok);

    file_ref = (file_len == '0) ? REF_ABSENT : (f_ok ? fill : REF_OVFL);
    func_ref = (func_len == '0) ? REF_ABSENT : (n_ok ? f_fill : REF_OVFL);
    locals_ref = REF_ABSENT;
    locals_bad = 1'b0;
    fill_next  = n_fill;
    if (!name_bad && locals_len != '0) begin
      if (l_ok) begin
        locals_ref = n_fill;
        fill_next  = l_sum[16:0];
      end else begin
        locals_bad = 1'b1;
      end
    end
  end
endmodule

/* rtl/trace_event_ring_with_string_pools_top.sv */
// Top level: trace event ring with two string pools.
//
// Channel | Dir | Handshake       | Payload
// s_axis  | in  | tvalid/tready   | tdata: action,seq_num,line_no,stack_depth,
//         |     |                 |   thread_ident,time_stamp,event_kind,file_len,
//         |     |                 |   func_len,locals_len,pop_limit
// m_axis  | out | tvalid/tready   | tdata: status..query_value, tlast: last
// cfg     | in  | cfg_we          | cfg_index, cfg_data
//
// Push, swap, clear and query are accepted, then answered from the result register.
// A pop of N entries is accepted, then per entry the slot memory is read and one
// output beat is sent; an empty pop is answered from the result register.
// Reset is synchronous; slot memory is not cleared. Output stalls hold the result.
module trace_event_ring_with_string_pools_top #(
  parameter int RING_DEPTH = terp_pkg::RING_DEPTH_DEF,
  parameter int POOL_BYTES = terp_pkg::POOL_BYTES_DEF,
  parameter int MAX_BATCH  = terp_pkg::MAX_BATCH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // action[2:0], seq_num[66:3], line_no[97:67], stack_depth[113:98],
  // thread_ident[177:114], time_stamp[241:178], event_kind[245:242],
  // file_len[262:246], func_len[279:263], locals_len[296:280], pop_limit[303:297]
  input  logic [terp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], out_sequence[65:2], out_line[96:66], out_depth[112:97],
  // out_thread[176:113], out_time[240:177], out_kind[244:241],
  // file_ref[261:245], func_ref[278:262], locals_ref[295:279], query_value[327:296]
  output logic [terp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [16:0]                     cfg_data
);
  import terp_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LGW = $clog2(AW + 1) + 1;

  // configuration
  logic [3:0]  capacity_log2;
  logic [16:0] pool_size;

  // state
  logic [31:0] head_count, tail_count, dropped_count, overflow_count;
  logic        active_pool;
  logic [16:0] pool_fill [2];
  ctl_state_t  state, state_next;
  logic [6:0]  remain;
  logic [31:0] rd_ptr;

  // input field views
  logic [2:0]  in_action;
  logic [16:0] in_flen, in_nlen, in_llen;
  logic [6:0]  in_maxc;
  assign in_action = s_axis_tdata[2:0];
  assign in_flen   = s_axis_tdata[262:246];
  assign in_nlen   = s_axis_tdata[279:263];
  assign in_llen   = s_axis_tdata[296:280];
  assign in_maxc   = s_axis_tdata[303:297];

  // capacity and mask
  logic [4:0]    lg_eff;
  logic [AW:0]   cap;
  logic [AW-1:0] mask;
  always_comb begin
    lg_eff = (capacity_log2 == 4'd0) ? 5'd1 : {1'b0, capacity_log2};
    if (32'(lg_eff) >= 32'(AW)) begin
      cap = (AW+1)'(RING_DEPTH);
    end else begin
      cap = (AW+1)'(1) << lg_eff;
    end
    mask = AW'(cap - (AW+1)'(1));
  end

  logic [16:0] limit;
  assign limit = ({15'd0, pool_size} > 32'(POOL_BYTES)) ? 17'(POOL_BYTES) : pool_size;

  // allocation
  logic [16:0] a_fref, a_nref, a_lref, a_fill_next;
  logic        a_name_bad, a_loc_bad;
  terp_alloc u_alloc (
    .fill(pool_fill[active_pool]), .limit(limit),
    .file_len(in_flen), .func_len(in_nlen), .locals_len(in_llen),
    .file_ref(a_fref), .func_ref(a_nref), .locals_ref(a_lref),
    .fill_next(a_fill_next), .name_bad(a_name_bad), .locals_bad(a_loc_bad)
  );

  logic s_fire, m_fire, full, push_ok;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign full   = (AW'(head_count + 32'd1) & mask) == (AW'(tail_count) & mask);
  assign push_ok = s_fire && in_action == ACT_PUSH && !full;
  assign s_axis_tready = (state == ST_IDLE);

  // slot memory
  logic [SLOT_W-1:0] wslot, rslot;
  assign wslot = {a_lref, a_nref, a_fref, s_axis_tdata[245:3]};
  terp_ram #(.WIDTH(SLOT_W), .DEPTH(RING_DEPTH)) u_slots (
    .clk(clk), .we(push_ok), .waddr(AW'(head_count) & mask), .wdata(wslot),
    .raddr(AW'(rd_ptr) & mask), .rdata(rslot)
  );

  // pop batch size
  logic [31:0] avail;
  logic [6:0]  maxc, pop_n;
  always_comb begin
    avail = head_count - tail_count;
    maxc = (in_maxc == 7'd0) ? 7'd1 : in_maxc;
    if (32'(maxc) > 32'(MAX_BATCH)) maxc = 7'(MAX_BATCH);
    pop_n = (avail < 32'(maxc)) ? avail[6:0] : maxc;
  end

  // fill percent: used*100/cap, cap a power of two
  logic [38:0] used100;
  logic [31:0] fill_pct;
  always_comb begin
    used100  = {7'd0, avail} * 39'd100;
    fill_pct = 32'(used100 >> LGW'(lg_eff >= 5'(AW) ? 5'(AW) : lg_eff));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = (in_action == ACT_POP && avail != '0) ? ST_POP_RD : ST_RESP;
        end
      end
      ST_POP_RD:  state_next = ST_POP_OUT;
      ST_POP_OUT: if (m_fire) state_next = (remain == 7'd1) ? ST_IDLE : ST_POP_RD;
      ST_RESP:    if (m_fire) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  assign m_axis_tvalid = (state == ST_POP_OUT) || (state == ST_RESP);

  logic [OUT_DATA_W-1:0] resp, resp_next;
  always_comb begin
    if (state == ST_POP_OUT) begin
      m_axis_tdata = {32'd0, rslot[SLOT_W-1:243], rslot[242:0], ST_OK};
      m_axis_tlast = (remain == 7'd1);
    end else begin
      m_axis_tdata = resp;
      m_axis_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      capacity_log2 <= 4'd10;
      pool_size <= 17'd65536;
      head_count <= '0;
      tail_count <= '0;
      dropped_count <= '0;
      overflow_count <= '0;
      active_pool <= 1'b0;
      pool_fill[0] <= '0;
      pool_fill[1] <= '0;
      remain <= '0;
      rd_ptr <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_CAP) capacity_log2 <= cfg_data[3:0];
        else pool_size <= cfg_data;
      end
      if (s_fire) begin
        case (in_action)
          ACT_PUSH: begin
            if (full) begin
              if (dropped_count != '1) dropped_count <= dropped_count + 32'd1;
            end else begin
              head_count <= head_count + 32'd1;
              pool_fill[active_pool] <= a_fill_next;
              if ((a_name_bad || a_loc_bad) && overflow_count != '1)
                overflow_count <= overflow_count + 32'd1;
            end
          end
          ACT_POP: begin
            remain <= pop_n;
            rd_ptr <= tail_count;
          end
          ACT_SWAP:  active_pool <= ~active_pool;
          ACT_CLEAR: pool_fill[~active_pool] <= '0;
          default: ;
        endcase
      end
      if (state == ST_POP_OUT && m_fire) begin
        remain <= remain - 7'd1;
        rd_ptr <= rd_ptr + 32'd1;
        tail_count <= tail_count + 32'd1;
      end
    end
  end

  // single-result value
  always_comb begin
    resp_next = '0;
    case (in_action)
      ACT_PUSH:  resp_next[1:0] = full ? ST_DROP : (a_name_bad ? ST_POOL : ST_OK);
      ACT_POP:   resp_next[1:0] = ST_EMPTY;
      ACT_FILL:  resp_next[327:296] = fill_pct;
      ACT_DROPS: resp_next[327:296] = dropped_count;
      ACT_OVFL:  resp_next[327:296] = overflow_count;
      default: ;
    endcase
  end

  // single-result register
  always_ff @(posedge clk) begin
    if (s_fire) begin
      resp <= resp_next;
    end
  end
endmodule
